@@ sv/ksf_pkg.sv @@
// Shared constants and types for the streaming spanning forest block.
// No dependencies; imported by every module of the block.
package ksf_pkg;

   localparam int VERTEX_COUNT = 64;
   localparam int VID_W        = 6;
   localparam int WEIGHT_W     = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int SIZE_W       = 8;
   localparam int SUM_W        = 24;
   localparam int SEG_CELLS    = 8;
   localparam int SEG_COUNT    = (VERTEX_COUNT + SEG_CELLS - 1) / SEG_CELLS;

   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

   typedef struct packed {
      logic              seen;
      logic [VID_W-1:0]  root;
      logic [SIZE_W-1:0] size;
   } look_type;

   typedef struct packed {
      look_type u;
      look_type v;
   } probe_type;

   typedef struct packed {
      logic [VID_W-1:0] u;
      logic [VID_W-1:0] v;
      logic             clear;
   } query_type;

   typedef struct packed {
      logic              write;
      logic              clear;
      logic              mark_a;
      logic [VID_W-1:0]  id_a;
      logic              mark_b;
      logic [VID_W-1:0]  id_b;
      logic              relabel;
      logic [VID_W-1:0]  old_a;
      logic [VID_W-1:0]  old_b;
      logic [VID_W-1:0]  new_root;
      logic [SIZE_W-1:0] new_size;
   } update_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_LOOK   = 3'b010,
      S_DECIDE = 3'b100
   } state_type;

endpackage

@@ sv/ksf_cell.sv @@
// One vertex cell: tree label, seen mark and replicated tree edge count.
// Adds its lookup answer to the probe word handed on from its neighbour.
// Depends on ksf_pkg.
module ksf_cell
   import ksf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [VID_W-1:0] cell_id,
   input  query_type        query,
   input  update_type       update,
   input  probe_type        probe_in,
   output probe_type        probe_out
);

   logic              seen_ff, seen_in;
   logic [VID_W-1:0]  root_ff, root_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   look_type          own;
   probe_type         contrib;
   logic              seen_base;
   logic [VID_W-1:0]  root_base;
   logic [SIZE_W-1:0] size_base;
   logic              hit;

   always_comb begin
      own.seen = seen_ff & ~query.clear;
      own.root = root_ff;
      own.size = size_ff;
      contrib.u = (cell_id == query.u) ? own : '0;
      contrib.v = (cell_id == query.v) ? own : '0;
      probe_out = probe_type'(probe_in | contrib);
   end

   always_comb begin
      seen_base = update.clear ? 1'b0 : seen_ff;
      root_base = update.clear ? '0 : root_ff;
      size_base = update.clear ? '0 : size_ff;
      hit = (update.relabel && seen_base &&
             (root_base == update.old_a || root_base == update.old_b)) ||
            (update.mark_a && cell_id == update.id_a) ||
            (update.mark_b && cell_id == update.id_b);
      seen_in = seen_ff;
      root_in = root_ff;
      size_in = size_ff;
      if (update.write) begin
         seen_in = hit ? 1'b1 : seen_base;
         root_in = hit ? update.new_root : root_base;
         size_in = hit ? update.new_size : size_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         root_ff <= '0;
         size_ff <= '0;
      end else begin
         seen_ff <= seen_in;
         root_ff <= root_in;
         size_ff <= size_in;
      end
   end

endmodule

@@ sv/ksf_ctrl.sv @@
// Handshake sequencer, edge decision, weight sum and result register.
// Issues the lookup query and the update command to the cell row. Depends on ksf_pkg.
module ksf_ctrl
   import ksf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_first_edge,
   input  logic [VID_W-1:0]    req_from_vertex,
   input  logic [VID_W-1:0]    req_to_vertex,
   input  logic [WEIGHT_W-1:0] req_edge_weight,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic [VID_W-1:0]    rsp_tree_root,
   output logic                rsp_merged,
   output logic [SUM_W-1:0]    rsp_total_weight,
   input  probe_type           probe,
   output query_type           query,
   output update_type          update
);

   state_type             state_ff, state_in;
   logic                  first_ff;
   logic [VID_W-1:0]      u_ff, v_ff;
   logic [WEIGHT_W-1:0]   w_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  rsp_valid_ff, acc_ff, merged_ff;
   logic [VID_W-1:0]      root_ff;
   logic [SUM_W-1:0]      total_ff;

   logic                  out_free, take, commit;
   logic                  acc, merged, in_range;
   logic [VID_W-1:0]      root;
   logic [SIZE_W:0]       grow;
   logic [SUM_W-1:0]      sum_base;
   logic [SUM_W:0]        sum_wide;

   function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W:0] s);
      return (s > {1'b0, SIZE_MAX}) ? SIZE_MAX : s[SIZE_W-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || (state_ff == S_DECIDE && out_free);
   assign take      = req_valid && req_ready;
   assign commit    = (state_ff == S_DECIDE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   state_in = take ? S_LOOK : S_IDLE;
         S_LOOK:   state_in = S_DECIDE;
         S_DECIDE: begin
            if (commit) state_in = req_valid ? S_LOOK : S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   assign query = '{u: u_ff, v: v_ff, clear: first_ff};

   always_comb begin
      acc      = 1'b0;
      merged   = 1'b0;
      root     = '0;
      grow     = '0;
      update   = '0;
      update.write = commit;
      update.clear = first_ff;
      in_range = ({1'b0, u_ff} < (VID_W + 1)'(VERTEX_COUNT)) &&
                 ({1'b0, v_ff} < (VID_W + 1)'(VERTEX_COUNT));
      priority if (!in_range) begin
         root = '0;
      end else if (u_ff == v_ff) begin
         root = probe.u.seen ? probe.u.root : u_ff;
      end else if (probe.u.seen && probe.v.seen && probe.u.root == probe.v.root) begin
         root = probe.u.root;
      end else if (!probe.u.seen && !probe.v.seen) begin
         acc             = 1'b1;
         root            = u_ff;
         update.mark_a   = 1'b1;
         update.id_a     = u_ff;
         update.mark_b   = 1'b1;
         update.id_b     = v_ff;
         update.new_root = u_ff;
         update.new_size = SIZE_W'(1);
      end else if (!probe.u.seen || !probe.v.seen) begin
         acc             = 1'b1;
         root            = probe.u.seen ? probe.u.root : probe.v.root;
         grow            = {1'b0, probe.u.seen ? probe.u.size : probe.v.size} + 1'b1;
         update.mark_a   = 1'b1;
         update.id_a     = probe.u.seen ? v_ff : u_ff;
         update.relabel  = 1'b1;
         update.old_a    = root;
         update.old_b    = root;
         update.new_root = root;
         update.new_size = sat_size(grow);
      end else begin
         acc             = 1'b1;
         merged          = 1'b1;
         root            = (probe.u.size < probe.v.size) ? probe.v.root : probe.u.root;
         grow            = {1'b0, probe.u.size} + {1'b0, probe.v.size} + 1'b1;
         update.relabel  = 1'b1;
         update.old_a    = probe.u.root;
         update.old_b    = probe.v.root;
         update.new_root = root;
         update.new_size = sat_size(grow);
      end
      sum_base = first_ff ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base} + (SUM_W + 1)'(w_ff[WEIGHT_BITS-1:0]);
      if (acc) sum_in = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
      else     sum_in = sum_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            sum_ff       <= sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         first_ff <= req_first_edge;
         u_ff     <= req_from_vertex;
         v_ff     <= req_to_vertex;
         w_ff     <= req_edge_weight;
      end
      if (commit) begin
         acc_ff    <= acc;
         merged_ff <= merged;
         root_ff   <= root;
         total_ff  <= sum_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_merged       = merged_ff;
   assign rsp_tree_root    = root_ff;
   assign rsp_total_weight = total_ff;

endmodule

@@ sv/kruskal_spanning_forest.sv @@
// Streaming spanning forest over edges presented in ascending weight order.
// Each edge word passes a lookup state, in which both ends are probed along the
// cell row, eight cells per registered segment, and a decide state, in which
// every vertex cell relabels in parallel and the result word is loaded. The next
// edge word can be accepted in the decide state of the one before it; a result
// not taken holds the next decision back.
// Top level: ksf_cell row and ksf_ctrl; depends on ksf_pkg.
module kruskal_spanning_forest
   import ksf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_first_edge,
   input  logic [VID_W-1:0]    req_from_vertex,
   input  logic [VID_W-1:0]    req_to_vertex,
   input  logic [WEIGHT_W-1:0] req_edge_weight,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic [VID_W-1:0]    rsp_tree_root,
   output logic                rsp_merged,
   output logic [SUM_W-1:0]    rsp_total_weight
);

   query_type  query;
   update_type update;
   probe_type  link [SEG_COUNT][SEG_CELLS+1];
   probe_type  seg_in [SEG_COUNT];
   probe_type  seg_ff [SEG_COUNT];
   probe_type  probe_all;

   for (genvar g = 0; g < SEG_COUNT; g++) begin : g_seg
      assign link[g][0] = '0;
      for (genvar c = 0; c < SEG_CELLS; c++) begin : g_cell
         localparam int IDX = g * SEG_CELLS + c;
         if (IDX < VERTEX_COUNT) begin : g_real
            ksf_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .cell_id   (VID_W'(IDX)),
               .query     (query),
               .update    (update),
               .probe_in  (link[g][c]),
               .probe_out (link[g][c+1])
            );
         end else begin : g_pad
            assign link[g][c+1] = link[g][c];
         end
      end
      assign seg_in[g] = link[g][SEG_CELLS];
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < SEG_COUNT; g++) begin
         seg_ff[g] <= seg_in[g];
      end
   end

   always_comb begin
      probe_all = '0;
      for (int g = 0; g < SEG_COUNT; g++) begin
         probe_all = probe_type'(probe_all | seg_ff[g]);
      end
   end

   ksf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_edge   (req_first_edge),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_edge_weight  (req_edge_weight),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_tree_root    (rsp_tree_root),
      .rsp_merged       (rsp_merged),
      .rsp_total_weight (rsp_total_weight),
      .probe            (probe_all),
      .query            (query),
      .update           (update)
   );

endmodule
